// ===== rtl/djq_pkg.sv =====
`timescale 1ns / 1ps
package djq_pkg;
    localparam int Depth = 16;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int JobW  = 40;

    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] pages;
        logic [15:0] id;
    } job_t;

    typedef enum logic [3:0] {
        FN_PUSH_N = 4'd0, FN_PUSH_P = 4'd1, FN_POP_N = 4'd2, FN_POP_P = 4'd3,
        FN_CAN_N = 4'd4, FN_CAN_P = 4'd5, FN_SRCH_N = 4'd6, FN_SRCH_P = 4'd7,
        FN_EXISTS = 4'd8
    } func_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_NSCAN, S_PSCAN, S_DONE
    } state_t;
endpackage

// ===== rtl/djq_ram.sv =====
`timescale 1ns / 1ps
module djq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/dual_job_queue_with_cancel.sv =====
`timescale 1ns / 1ps
// Two job queues (normal and priority), each held in a RAM with a registered read port.
// One item is in work at a time. A push goes from accept through S_DONE to the next accept.
// A priority pop reads only the head entry. A normal pop, a search or a cancel
// walks its queue one entry per cycle, because the RAM read port gives one entry per
// cycle, and a normal pop also shifts the rest down.
// Exists walks both queues. The result sits in an output register while the next item is
// taken. An item only finishes once that register is free, so a stalled m_tready holds
// the block after at most one more item.
module dual_job_queue_with_cancel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // func[3:0], job_id[19:4], page_count[35:20], job_kind[43:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // status[1:0], out_id[17:2], out_pages[33:18],
                                  // out_kind[41:34], normal_level[46:42], priority_level[51:47]
);
    localparam int AW = djq_pkg::AddrW;
    localparam int CW = djq_pkg::CntW;

    djq_pkg::state_t state_reg, state_next;
    logic [3:0]  func_reg;
    djq_pkg::job_t req_reg;
    logic [CW-1:0] ncnt_reg, pcnt_reg, ncnt_next, pcnt_next;
    logic [AW-1:0] phead_reg, ptail_reg, phead_next, ptail_next;
    logic [CW-1:0] idx_reg, idx_next;      // entries issued for read
    logic          rv_reg;                 // read data valid this cycle
    logic [CW-1:0] kept_reg, kept_next;    // write slot for compaction
    logic          hit_reg, hit_next;
    djq_pkg::job_t rep_reg, rep_next;
    logic [1:0]    st_reg, st_next;
    logic          out_v_reg;
    logic [55:0]   out_d_reg;

    logic          n_we, p_we;
    logic [AW-1:0] n_wa, p_wa, n_ra, p_ra;
    logic [39:0]   n_wd, p_wd, n_rd, p_rd;
    djq_pkg::job_t n_job, p_job;
    assign n_job = djq_pkg::job_t'(n_rd);
    assign p_job = djq_pkg::job_t'(p_rd);

    djq_ram #(.Width(djq_pkg::JobW), .Depth(djq_pkg::Depth)) u_nram (
        .aclk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
    djq_ram #(.Width(djq_pkg::JobW), .Depth(djq_pkg::Depth)) u_pram (
        .aclk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    logic accept;
    assign s_tready = (state_reg == djq_pkg::S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata = out_d_reg;

    logic rd_n_last, rd_p_last;
    assign rd_n_last = rv_reg && (idx_reg == ncnt_reg);
    assign rd_p_last = rv_reg && (idx_reg == pcnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            djq_pkg::S_IDLE: if (accept) state_next = djq_pkg::S_DONE;
            djq_pkg::S_NSCAN: if (rd_n_last || (!rv_reg && ncnt_reg == '0)
                                  || (hit_next && func_reg != djq_pkg::FN_CAN_N
                                      && func_reg != djq_pkg::FN_POP_N))
                state_next = djq_pkg::S_DONE;
            djq_pkg::S_PSCAN: if (rd_p_last || (!rv_reg && pcnt_reg == '0)
                                  || (hit_next && func_reg != djq_pkg::FN_CAN_P))
                state_next = djq_pkg::S_DONE;
            djq_pkg::S_DONE: if (!out_v_reg || m_tready) state_next = djq_pkg::S_IDLE;
            default: state_next = djq_pkg::S_IDLE;
        endcase
        if (state_reg == djq_pkg::S_IDLE && accept) begin
            unique case (djq_pkg::func_t'(s_tdata[3:0]))
                djq_pkg::FN_POP_N, djq_pkg::FN_CAN_N, djq_pkg::FN_SRCH_N, djq_pkg::FN_EXISTS:
                    state_next = djq_pkg::S_NSCAN;
                djq_pkg::FN_POP_P, djq_pkg::FN_CAN_P, djq_pkg::FN_SRCH_P:
                    state_next = djq_pkg::S_PSCAN;
                default: state_next = djq_pkg::S_DONE;
            endcase
        end
        if (state_reg == djq_pkg::S_NSCAN && state_next == djq_pkg::S_DONE
            && func_reg == djq_pkg::FN_EXISTS && !hit_next)
            state_next = djq_pkg::S_PSCAN;
    end

    // datapath
    always_comb begin
        ncnt_next = ncnt_reg; pcnt_next = pcnt_reg;
        phead_next = phead_reg; ptail_next = ptail_reg;
        idx_next = idx_reg; kept_next = kept_reg; hit_next = hit_reg;
        rep_next = rep_reg; st_next = st_reg;
        n_we = 1'b0; p_we = 1'b0;
        n_wa = AW'(kept_reg); p_wa = AW'(kept_reg);
        n_wd = n_rd; p_wd = p_rd;
        n_ra = AW'(idx_reg); p_ra = phead_reg + AW'(idx_reg);
        unique case (state_reg)
            djq_pkg::S_IDLE: begin
                idx_next = '0; kept_next = '0; hit_next = 1'b0;
                rep_next = '0; st_next = djq_pkg::ST_OK;
                if (accept) begin
                    if (s_tdata[3:0] == djq_pkg::FN_PUSH_N) begin
                        if (ncnt_reg == CW'(djq_pkg::Depth)) st_next = djq_pkg::ST_FULL;
                        else begin
                            n_we = 1'b1; n_wa = AW'(ncnt_reg); n_wd = s_tdata[43:4];
                            ncnt_next = ncnt_reg + 1'b1;
                        end
                    end else if (s_tdata[3:0] == djq_pkg::FN_PUSH_P) begin
                        if (pcnt_reg == CW'(djq_pkg::Depth)) st_next = djq_pkg::ST_FULL;
                        else begin
                            p_we = 1'b1; p_wa = ptail_reg; p_wd = s_tdata[43:4];
                            ptail_next = ptail_reg + 1'b1;
                            pcnt_next = pcnt_reg + 1'b1;
                        end
                    end
                end
            end
            djq_pkg::S_NSCAN: begin
                if (idx_reg < ncnt_reg) idx_next = idx_reg + 1'b1;
                n_ra = AW'(idx_reg);
                if (rv_reg) begin
                    if (func_reg == djq_pkg::FN_POP_N) begin
                        // pop is a cancel of the first entry
                        if (!hit_reg) begin
                            hit_next = 1'b1; rep_next = n_job;
                        end else begin
                            n_we = 1'b1; kept_next = kept_reg + 1'b1;
                        end
                    end else if (!hit_reg && n_job.id == req_reg.id) begin
                        hit_next = 1'b1; rep_next = n_job;
                    end else if (func_reg == djq_pkg::FN_CAN_N) begin
                        n_we = hit_reg; kept_next = kept_reg + 1'b1;
                    end
                end
                if (state_next != djq_pkg::S_NSCAN) begin
                    if (func_reg == djq_pkg::FN_POP_N) begin
                        if (!hit_next) st_next = djq_pkg::ST_EMPTY;
                        else ncnt_next = ncnt_reg - 1'b1;
                    end else if (!hit_next) begin
                        if (func_reg != djq_pkg::FN_EXISTS) st_next = djq_pkg::ST_NOTFOUND;
                    end else if (func_reg == djq_pkg::FN_CAN_N) ncnt_next = ncnt_reg - 1'b1;
                    idx_next = '0; kept_next = '0;
                end
            end
            djq_pkg::S_PSCAN: begin
                if (idx_reg < pcnt_reg) idx_next = idx_reg + 1'b1;
                if (func_reg == djq_pkg::FN_POP_P) begin
                    if (pcnt_reg == '0) st_next = djq_pkg::ST_EMPTY;
                    else if (rv_reg) begin
                        rep_next = p_job; hit_next = 1'b1;
                        phead_next = phead_reg + 1'b1;
                        pcnt_next = pcnt_reg - 1'b1;
                    end
                end else if (rv_reg) begin
                    if (p_job.id == req_reg.id) begin
                        if (!hit_reg) begin
                            hit_next = 1'b1; rep_next = p_job;
                        end
                    end else if (func_reg == djq_pkg::FN_CAN_P) begin
                        // survivors repacked from the head slot, so writes trail reads
                        // by less than one turn of the ring
                        p_we = 1'b1; p_wa = phead_reg + AW'(kept_reg);
                        kept_next = kept_reg + 1'b1;
                    end
                end
                if (state_next != djq_pkg::S_PSCAN && func_reg != djq_pkg::FN_POP_P) begin
                    if (!hit_next) st_next = djq_pkg::ST_NOTFOUND;
                    else if (func_reg == djq_pkg::FN_CAN_P) begin
                        pcnt_next = kept_next;
                        ptail_next = phead_reg + AW'(kept_next);
                    end
                end
            end
            djq_pkg::S_DONE: ;
            default: ;
        endcase
    end

    // state, queue levels and output valid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= djq_pkg::S_IDLE;
            ncnt_reg <= '0; pcnt_reg <= '0; phead_reg <= '0; ptail_reg <= '0;
            out_v_reg <= 1'b0; rv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ncnt_reg <= ncnt_next; pcnt_reg <= pcnt_next;
            phead_reg <= phead_next; ptail_reg <= ptail_next;
            rv_reg <= (state_next == djq_pkg::S_NSCAN || state_next == djq_pkg::S_PSCAN)
                      && (state_next == state_reg) && (idx_reg != idx_next);
            if (state_reg == djq_pkg::S_DONE && (!out_v_reg || m_tready))
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_tdata[3:0];
            req_reg <= djq_pkg::job_t'(s_tdata[43:4]);
        end
        idx_reg <= idx_next; kept_reg <= kept_next; hit_reg <= hit_next;
        rep_reg <= rep_next; st_reg <= st_next;
        if (state_reg == djq_pkg::S_DONE && (!out_v_reg || m_tready))
            out_d_reg <= {4'd0, pcnt_reg, ncnt_reg,
                          (st_reg == djq_pkg::ST_OK) ? rep_reg : djq_pkg::job_t'('0), st_reg};
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ncnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ncnt_reg <= CW'(djq_pkg::Depth) && pcnt_reg <= CW'(djq_pkg::Depth))
        else $error("queue level out of range");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("item taken while busy");
endmodule

// ===== tb/tb_dual_job_queue_with_cancel.sv =====
`timescale 1ns / 1ps
module tb_dual_job_queue_with_cancel;

    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] pages;
        logic [7:0]  kind;
        logic [4:0]  nlev;
        logic [4:0]  plev;
    } reply_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] id;
        logic [15:0] pages;
        logic [7:0]  kind;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    dual_job_queue_with_cancel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // queue shadow state
    djq_pkg::job_t nq[$];
    djq_pkg::job_t pq[$];
    request_t pending[$];
    reply_t   replies_due[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sender_hold = 0;
    bit rx_stall_arm = 0;    // long receiver stall, armed by the stimulus

    function automatic reply_t predict_reply(request_t r);
        reply_t o;
        djq_pkg::job_t j;
        int n;
        djq_pkg::job_t kept[$];
        bit hit;
        o = '0;
        o.status = djq_pkg::ST_OK;
        j.id = r.id; j.pages = r.pages; j.kind = r.kind;
        case (r.func)
            djq_pkg::FN_PUSH_N:
                if (nq.size() >= djq_pkg::Depth) o.status = djq_pkg::ST_FULL;
                else nq.push_back(j);
            djq_pkg::FN_PUSH_P:
                if (pq.size() >= djq_pkg::Depth) o.status = djq_pkg::ST_FULL;
                else pq.push_back(j);
            djq_pkg::FN_POP_N: begin
                if (nq.size() == 0) o.status = djq_pkg::ST_EMPTY;
                else begin j = nq.pop_front(); o.id = j.id; o.pages = j.pages; o.kind = j.kind; end
            end
            djq_pkg::FN_POP_P: begin
                if (pq.size() == 0) o.status = djq_pkg::ST_EMPTY;
                else begin j = pq.pop_front(); o.id = j.id; o.pages = j.pages; o.kind = j.kind; end
            end
            djq_pkg::FN_CAN_N, djq_pkg::FN_SRCH_N, djq_pkg::FN_EXISTS: begin
                n = -1;
                foreach (nq[i]) if (n < 0 && nq[i].id == r.id) n = i;
                if (n >= 0) begin
                    j = nq[n]; o.id = j.id; o.pages = j.pages; o.kind = j.kind;
                    if (r.func == djq_pkg::FN_CAN_N) nq.delete(n);
                end else if (r.func == djq_pkg::FN_EXISTS) begin
                    foreach (pq[i]) if (n < 0 && pq[i].id == r.id) n = i;
                    if (n >= 0) begin j = pq[n]; o.id = j.id; o.pages = j.pages; o.kind = j.kind; end
                    else o.status = djq_pkg::ST_NOTFOUND;
                end else o.status = djq_pkg::ST_NOTFOUND;
            end
            djq_pkg::FN_SRCH_P: begin
                n = -1;
                foreach (pq[i]) if (n < 0 && pq[i].id == r.id) n = i;
                if (n >= 0) begin j = pq[n]; o.id = j.id; o.pages = j.pages; o.kind = j.kind; end
                else o.status = djq_pkg::ST_NOTFOUND;
            end
            djq_pkg::FN_CAN_P: begin
                hit = 0;
                foreach (pq[i]) begin
                    if (pq[i].id != r.id) kept.push_back(pq[i]);
                    else if (!hit) begin
                        hit = 1; o.id = pq[i].id; o.pages = pq[i].pages; o.kind = pq[i].kind;
                    end
                end
                if (hit) pq = kept; else o.status = djq_pkg::ST_NOTFOUND;
            end
            default: ;
        endcase
        o.nlev = 5'(nq.size());
        o.plev = 5'(pq.size());
        return o;
    endfunction

    function automatic request_t make_request(logic [3:0] f, logic [15:0] id,
                                              logic [15:0] pg, logic [7:0] k);
        request_t r;
        r.func = f; r.id = id; r.pages = pg; r.kind = k;
        return r;
    endfunction

    // accept seen at the rising edge; the item leaves the pending queue there
    bit took = 0;
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            replies_due.push_back(predict_reply(pending.pop_front()));
            took <= 1'b1;
        end else begin
            took <= 1'b0;
        end
    end

    // driver
    int tx_wait = 0;
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || took)) begin
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (!sender_hold && pending.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, pending[0].kind, pending[0].pages,
                            pending[0].id, pending[0].func};
                tx_wait <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result accept seen at the rising edge
    bit rx_took = 0;
    always @(posedge aclk) rx_took <= aresetn && m_tvalid && m_tready;

    // receiver
    int rx_wait = 0;
    int rx_stall = 0;
    bit rx_stall_used = 0;
    always @(negedge aclk) begin
        int w;
        if (aresetn) begin
            if (rx_stall_arm && !rx_stall_used) begin
                rx_stall_used <= 1'b1;
                rx_stall <= 300;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else if (rx_took) begin
                w = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    rx_wait <= w - 1;
                    m_tready <= 1'b0;
                end
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        reply_t got, exp_r;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.id = m_tdata[17:2];
                got.pages = m_tdata[33:18];
                got.kind = m_tdata[41:34];
                got.nlev = m_tdata[46:42];
                got.plev = m_tdata[51:47];
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = replies_due.pop_front();
                    if (got.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                        errors++;
                    end
                    if (got.id !== exp_r.id) begin
                        $display("%0t: id exp %h got %h", $time, exp_r.id, got.id);
                        errors++;
                    end
                    if (got.pages !== exp_r.pages) begin
                        $display("%0t: pages exp %h got %h", $time, exp_r.pages, got.pages);
                        errors++;
                    end
                    if (got.kind !== exp_r.kind) begin
                        $display("%0t: kind exp %h got %h", $time, exp_r.kind, got.kind);
                        errors++;
                    end
                    if (got.nlev !== exp_r.nlev) begin
                        $display("%0t: normal level exp %0d got %0d", $time, exp_r.nlev, got.nlev);
                        errors++;
                    end
                    if (got.plev !== exp_r.plev) begin
                        $display("%0t: priority level exp %0d got %0d", $time, exp_r.plev,
                                 got.plev);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // small id pool makes matches and duplicates common
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [3:0] pick_func(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 4'($urandom_range(9, 15));
        // phases lean toward filling or draining
        if (phase == 0) begin
            if (r < 45) return 4'($urandom_range(0, 1));
            return 4'($urandom_range(2, 8));
        end else if (phase == 1) begin
            if (r < 20) return 4'($urandom_range(0, 1));
            if (r < 45) return 4'($urandom_range(2, 3));
            return 4'($urandom_range(4, 8));
        end
        return 4'($urandom_range(0, 8));
    endfunction

    initial begin
        logic [3:0] f;
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty cases, extremes, full queues, cancel of duplicates
        pending.push_back(make_request(djq_pkg::FN_POP_N, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_POP_P, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_CAN_N, 16'hFFFF, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_CAN_P, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_SRCH_N, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_SRCH_P, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_EXISTS, 0, 0, 0));
        pending.push_back(make_request(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF));
        pending.push_back(make_request(4'd9, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_PUSH_N, 16'hFFFF, 16'hFFFF, 8'hFF));
        pending.push_back(make_request(djq_pkg::FN_PUSH_P, 16'hFFFF, 16'h0000, 8'h00));
        pending.push_back(make_request(djq_pkg::FN_PUSH_P, 16'h0001, 16'h1234, 8'h41));
        pending.push_back(make_request(djq_pkg::FN_PUSH_P, 16'hFFFF, 16'h5555, 8'hAA));
        pending.push_back(make_request(djq_pkg::FN_EXISTS, 16'hFFFF, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_SRCH_P, 16'h0001, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_CAN_P, 16'hFFFF, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_POP_P, 0, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_CAN_N, 16'hFFFF, 0, 0));
        for (int i = 0; i < 17; i++) begin
            pending.push_back(make_request(djq_pkg::FN_PUSH_N, 16'(i % 3), 16'($urandom),
                                           8'($urandom)));
            pending.push_back(make_request(djq_pkg::FN_PUSH_P, 16'(i % 3), 16'($urandom),
                                           8'($urandom)));
        end
        pending.push_back(make_request(djq_pkg::FN_CAN_N, 1, 0, 0));
        pending.push_back(make_request(djq_pkg::FN_CAN_P, 2, 0, 0));

        // receiver stalls long while the sender keeps offering
        rx_stall_arm = 1;
        wait (pending.size() == 0 && replies_due.size() == 0);

        for (int n = 0; n < 1100; n++) begin
            phase = (n / 60) % 3;
            f = pick_func(phase);
            pending.push_back(make_request(f, pick_id(), 16'($urandom_range(0, 65535)),
                                           8'($urandom_range(0, 255))));
            if (n == 550) begin
                // sender pauses until every result has come back
                wait (pending.size() == 0);
                sender_hold = 1;
                wait (replies_due.size() == 0);
                sender_hold = 0;
            end
            if (pending.size() > 40) wait (pending.size() < 20);
        end
        wait (pending.size() == 0 && replies_due.size() == 0);
        repeat (2 * djq_pkg::Depth + 10) @(posedge aclk);
        if (errors == 0 && replies_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
